// File: sv/lpw_pkg.sv
// Shared constants, codes and controller/datapath interface types of the line pixel walker.
package lpw_pkg;

    // Coordinate width and the widths that follow from it.
    localparam int CB        = 12;                 // coordinate bits
    localparam int DW        = CB + 1;             // width of a coordinate difference
    localparam int NUM_W     = 2 * DW;             // product, numerator and quotient width
    localparam int CNT_W     = $clog2(NUM_W + 1);  // divider step counter
    localparam int CFG_IDX_W = 2;                  // configuration register index
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = ((2 * CB + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_X   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 2'd3;

    // Line kinds, latched at restart.
    localparam logic [1:0] K_VERT   = 2'd0;
    localparam logic [1:0] K_HORZ   = 2'd1;
    localparam logic [1:0] K_SLOPED = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init;       // restart beat accepted: latch kind and first position
        logic mul_a;      // accumulator = start_y * dx
        logic mul_b;      // accumulator += dy * (walk_x - start_x)
        logic div_start;  // start |numerator| / |dx|
        logic col_load;   // take the row of the current column
        logic col_init;   // with col_load: first column of a restart
        logic emit;       // produce the result of this beat and advance the walk
        logic out_load;   // move the held result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sloped_cfg; // registers describe a sloped line
        logic need_col;   // the emit step moves to a new column
        logic div_done;   // quotient is ready
        logic out_free;   // output register can take a result
    } t_status;

endpackage

// File: sv/line_pixel_walker.sv
// Top level of the line pixel walker: stream ports, configuration port, controller and datapath.
//
// The block walks the pixels of a straight line between two endpoints held in four
// configuration registers (start_x, start_y, end_x, end_y, 12-bit two's complement,
// indexes 0 to 3). Every input beat produces exactly one output beat. A beat with the
// restart bit set begins a new walk and returns its first pixel; a beat with it clear
// returns the next pixel. A vertical line walks y from start_y toward end_y and leaves
// end_y out; a horizontal line does the same along x. Any other line walks x from the
// smaller to the larger end, both ends included, and at each column uses the row
// start_y + dy*(x - start_x)/dx computed exactly and truncated toward zero; when the
// row jumps by more than one, the rows in between are returned first at the new
// column. Once the walk is over, or for a line whose endpoints coincide, beats come
// back with pixel_valid (tuser) low and all other fields zero; tlast marks the final
// pixel. A straight-line step or a gap-fill row passes from acceptance through the emit
// and output states only. A step that enters a new column of a sloped line first builds
// the numerator on the shared multiplier (mul_a, then mul_b), then runs a restoring
// divider that retires one quotient bit per cycle and loads the row once the quotient is
// done. A restart of a sloped line computes two columns. A stalled output side adds its
// wait to each beat. A new beat is accepted while the previous result still waits in
// the output register. Registers may be written whenever all accepted beats have been
// delivered.
module line_pixel_walker
    import lpw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Step input.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] restart, rest unused
    // Pixel output.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [11:0] pixel_x, [23:12] pixel_y
    output logic [0:0]             m_axis_tuser,   // [0] pixel_valid
    output logic                   m_axis_tlast,   // is_last
    // Configuration writes.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CB-1:0]          i_cfg_data
);

    t_cmd          cmd;
    t_status       status;
    logic [CB-1:0] pixel_x;
    logic [CB-1:0] pixel_y;
    logic          pixel_valid;

    // The controller owns input acceptance and the order of datapath operations.
    lpw_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_restart (s_axis_tdata[0]),
        .o_in_ready   (s_axis_tready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // The datapath holds the endpoints, the walk state and the output register.
    lpw_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_pixel_x     (pixel_x),
        .o_pixel_y     (pixel_y),
        .o_pixel_valid (pixel_valid),
        .o_is_last     (m_axis_tlast)
    );

    // Coordinates packed from the lowest bit up, padded with zeros to whole bytes.
    assign m_axis_tdata = OUT_TDATA_W'({pixel_y, pixel_x});
    assign m_axis_tuser = pixel_valid;

endmodule

// File: sv/lpw_div.sv
// Restoring divider, one quotient bit per cycle, unsigned numerator by unsigned divisor.
module lpw_div
    import lpw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [CB-1:0]    i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [CB-1:0]    r_rem;

    logic [CB:0]   rem_sh;
    logic          q_bit;
    logic [CB-1:0] n_rem;

    // Shift in the next numerator bit and try a subtraction.
    always_comb begin
        rem_sh = {r_rem, r_quo[NUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, i_divisor});
        n_rem  = q_bit ? CB'(rem_sh - {1'b0, i_divisor}) : rem_sh[CB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_run) begin
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_run))
        else $error("divider finished without running");

    a_no_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_run)
        else $error("divider started while busy");

endmodule

// File: sv/lpw_dp.sv
// Datapath: endpoint registers, walk state, row arithmetic and the output register.
module lpw_dp
    import lpw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CB-1:0]        i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [CB-1:0]        o_pixel_x,
    output logic [CB-1:0]        o_pixel_y,
    output logic                 o_pixel_valid,
    output logic                 o_is_last
);

    localparam logic signed [CB-1:0] C_ONE = 1;

    // Endpoint registers.
    logic signed [CB-1:0] r_start_x, r_start_y, r_end_x, r_end_y;

    // Walk state.
    logic signed [CB-1:0] r_walk_x, r_walk_y, r_prev_row;
    logic signed [CB-1:0] n_walk_x, n_walk_y, n_prev_row;
    logic [1:0]           r_kind, n_kind;
    logic                 r_gap, n_gap;
    logic                 r_done, n_done;

    // Result of the current beat, held until the output register is free.
    logic [CB-1:0] r_res_x, r_res_y, n_res_x, n_res_y;
    logic          r_res_pv, r_res_last, n_res_pv, n_res_last;

    // Output register.
    logic          r_out_valid;
    logic [CB-1:0] r_out_x, r_out_y;
    logic          r_out_pv, r_out_last;

    // Row arithmetic.
    logic signed [NUM_W-1:0] r_acc;
    logic                    r_qsign;
    logic signed [DW-1:0]    dx, dy, xd, mul_a_op, mul_b_op;
    logic signed [NUM_W-1:0] prod, row, q;
    logic signed [NUM_W:0]   row_d;
    logic                    gap_new;
    logic [NUM_W-1:0]        div_num, div_quot;
    logic [CB-1:0]           dx_abs;
    logic                    div_done;

    logic signed [CB-1:0] xfin, x_min, nx, ny, p_next;
    logic                 x_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_X: r_start_x <= i_cfg_data;
                REG_START_Y: r_start_y <= i_cfg_data;
                REG_END_X:   r_end_x   <= i_cfg_data;
                REG_END_Y:   r_end_y   <= i_cfg_data;
                default:     r_start_x <= r_start_x;
            endcase
        end
    end

    // Numerator sy*dx + dy*(x - sx) built on one shared multiplier in the mul_a and mul_b steps.
    // The magnitude of dx never exceeds 4095, so it fits the coordinate width unsigned.
    always_comb begin
        dx       = DW'(r_end_x) - DW'(r_start_x);
        dy       = DW'(r_end_y) - DW'(r_start_y);
        xd       = DW'(r_walk_x) - DW'(r_start_x);
        mul_a_op = i_cmd.mul_a ? DW'(r_start_y) : dy;
        mul_b_op = i_cmd.mul_a ? dx : xd;
        prod     = mul_a_op * mul_b_op;
        div_num  = r_acc[NUM_W-1] ? NUM_W'(-r_acc) : NUM_W'(r_acc);
        dx_abs   = dx[DW-1] ? CB'(-dx) : dx[CB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a) begin
            r_acc <= prod;
        end else if (i_cmd.mul_b) begin
            r_acc <= r_acc + prod;
        end
        if (i_cmd.div_start) begin
            r_qsign <= r_acc[NUM_W-1] ^ dx[DW-1];
        end
    end

    lpw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (dx_abs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Quotient truncated toward zero; a line with no x extent keeps start_y.
    always_comb begin
        q       = r_qsign ? -$signed(div_quot) : $signed(div_quot);
        row     = (dx == '0) ? NUM_W'(r_start_y) : q;
        row_d   = (NUM_W + 1)'(row) - (NUM_W + 1)'(r_prev_row);
        gap_new = (row_d > 1) || (row_d < -1);
    end

    always_comb begin
        xfin   = (r_start_x > r_end_x) ? r_start_x : r_end_x;
        x_min  = (r_start_x < r_end_x) ? r_start_x : r_end_x;
        x_last = (r_walk_x >= xfin);
        nx     = (r_walk_x < r_end_x) ? r_walk_x + C_ONE : r_walk_x - C_ONE;
        ny     = (r_walk_y < r_end_y) ? r_walk_y + C_ONE : r_walk_y - C_ONE;
        p_next = (r_prev_row < r_walk_y) ? r_prev_row + C_ONE : r_prev_row - C_ONE;
    end

    always_comb begin
        n_walk_x   = r_walk_x;
        n_walk_y   = r_walk_y;
        n_prev_row = r_prev_row;
        n_kind     = r_kind;
        n_gap      = r_gap;
        n_done     = r_done;
        n_res_x    = r_res_x;
        n_res_y    = r_res_y;
        n_res_pv   = r_res_pv;
        n_res_last = r_res_last;

        if (i_cmd.init) begin
            n_gap    = 1'b0;
            n_done   = 1'b0;
            n_walk_y = r_start_y;
            if (r_start_x == r_end_x) begin
                n_kind   = K_VERT;
                n_walk_x = r_start_x;
            end else if (r_start_y == r_end_y) begin
                n_kind   = K_HORZ;
                n_walk_x = r_start_x;
            end else begin
                n_kind   = K_SLOPED;
                n_walk_x = x_min;
            end
        end

        if (i_cmd.col_load) begin
            n_walk_y = row[CB-1:0];
            if (i_cmd.col_init) begin
                n_prev_row = row[CB-1:0];
                n_gap      = 1'b0;
            end else begin
                n_gap = gap_new;
            end
        end

        if (i_cmd.emit) begin
            n_res_x    = '0;
            n_res_y    = '0;
            n_res_pv   = 1'b0;
            n_res_last = 1'b0;
            if (!r_done) begin
                case (r_kind)
                    K_SLOPED: begin
                        n_res_x  = r_walk_x;
                        n_res_pv = 1'b1;
                        if (r_gap) begin
                            // Fill the rows between the previous and the new row.
                            n_res_y    = r_prev_row;
                            n_prev_row = p_next;
                            if (p_next == r_walk_y) begin
                                n_gap = 1'b0;
                            end
                        end else begin
                            n_res_y    = r_walk_y;
                            n_res_last = x_last;
                            if (x_last) begin
                                n_done = 1'b1;
                            end else begin
                                n_prev_row = r_walk_y;
                                n_walk_x   = r_walk_x + C_ONE;
                            end
                        end
                    end
                    K_HORZ: begin
                        if (r_walk_x == r_end_x) begin
                            n_done = 1'b1;
                        end else begin
                            n_res_x    = r_walk_x;
                            n_res_y    = r_walk_y;
                            n_res_pv   = 1'b1;
                            n_res_last = (nx == r_end_x);
                            n_walk_x   = nx;
                            n_done     = (nx == r_end_x);
                        end
                    end
                    default: begin
                        if (r_walk_y == r_end_y) begin
                            n_done = 1'b1;
                        end else begin
                            n_res_x    = r_walk_x;
                            n_res_y    = r_walk_y;
                            n_res_pv   = 1'b1;
                            n_res_last = (ny == r_end_y);
                            n_walk_y   = ny;
                            n_done     = (ny == r_end_y);
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_x   <= '0;
            r_walk_y   <= '0;
            r_prev_row <= '0;
            r_kind     <= K_VERT;
            r_gap      <= 1'b0;
            r_done     <= 1'b1;
        end else begin
            r_walk_x   <= n_walk_x;
            r_walk_y   <= n_walk_y;
            r_prev_row <= n_prev_row;
            r_kind     <= n_kind;
            r_gap      <= n_gap;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_x    <= n_res_x;
        r_res_y    <= n_res_y;
        r_res_pv   <= n_res_pv;
        r_res_last <= n_res_last;
        if (i_cmd.out_load) begin
            r_out_x    <= r_res_x;
            r_out_y    <= r_res_y;
            r_out_pv   <= r_res_pv;
            r_out_last <= r_res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_status.sloped_cfg = (r_start_x != r_end_x) && (r_start_y != r_end_y);
        o_status.need_col   = (r_kind == K_SLOPED) && !r_done && !r_gap && !x_last;
        o_status.div_done   = div_done;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_valid = r_out_pv;
    assign o_is_last     = r_out_last;

    a_gap_only_sloped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap |-> (r_kind == K_SLOPED))
        else $error("row fill active on a straight line");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before it was taken");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_pv) |-> (r_out_x == '0 && r_out_y == '0 && !r_out_last))
        else $error("empty result carries nonzero fields");

endmodule

// File: sv/lpw_ctrl.sv
// Controller state machine: sequences each step beat through the datapath.
module lpw_ctrl
    import lpw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_restart,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MUL_A    = 3'd1;
    localparam logic [2:0] S_MUL_B    = 3'd2;
    localparam logic [2:0] S_DIV_GO   = 3'd3;
    localparam logic [2:0] S_DIV_WAIT = 3'd4;
    localparam logic [2:0] S_COL      = 3'd5;
    localparam logic [2:0] S_EMIT     = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_col_init, n_col_init;

    always_comb begin
        n_state    = r_state;
        n_col_init = r_col_init;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.init = i_in_restart;
                    if (i_in_restart && i_status.sloped_cfg) begin
                        n_col_init = 1'b1;
                        n_state    = S_MUL_A;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_COL;
                end
            end
            S_COL: begin
                o_cmd.col_load = 1'b1;
                o_cmd.col_init = r_col_init;
                n_state        = r_col_init ? S_EMIT : S_OUT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.need_col) begin
                    n_col_init = 1'b0;
                    n_state    = S_MUL_A;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_col_init <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col_init <= n_col_init;
        end
    end

endmodule

// File: verif/tb_line_pixel_walker.sv
// Self-checking testbench for the line pixel walker: stimulus, register writes and a predictor.
`timescale 1ns / 100ps

module tb_line_pixel_walker
    import lpw_pkg::*;
();

    // The run ends with a failure if it is still going after this many cycles. The slowest
    // correct run (every beat a sloped restart, both sides stalling) stays well below a third
    // of it.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int TARGET_STEPS = 1750;

    // One output beat as the block should deliver it.
    typedef struct packed {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic          valid;
        logic          last;
    } t_pixel_beat;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [0] restart, rest zero
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [11:0] pixel_x, [23:12] pixel_y
    logic [0:0]             m_axis_tuser;         // [0] pixel_valid
    logic                   m_axis_tlast;         // is_last
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CB-1:0]          i_cfg_data    = '0;

    // Step beats waiting to be driven, and pixels waiting to come back, oldest first.
    logic [IN_TDATA_W-1:0] step_queue[$];
    t_pixel_beat           expected_pixels[$];

    // Percentage of cycles in which each side holds back; zero for one long stretch.
    int idle_pct = 35;

    // Shadow copy of the endpoint registers, updated on each accepted register write.
    logic [CB-1:0] cfg_sx = '0, cfg_sy = '0, cfg_ex = '0, cfg_ey = '0;

    // Walk state of the predictor, as it stands after reset.
    logic [CB-1:0] col_x    = '0;    // current column, or fixed column of a vertical line
    logic [CB-1:0] row_y    = '0;    // current row, or target row of the current column
    logic [CB-1:0] fill_row = '0;    // row being emitted while a gap is filled
    logic [1:0]    kind_q   = K_VERT;
    logic          filling  = 1'b0;
    logic          finished = 1'b1;  // nothing to emit until the first restart

    int n_errors = 0, n_cycles = 0, n_queued = 0, n_steps_sent = 0, n_reg_writes = 0;
    int n_beats_checked = 0, n_pixels = 0, n_line_ends = 0;
    int n_vert = 0, n_horz = 0, n_sloped = 0, n_gap_rows = 0;

    line_pixel_walker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    function automatic longint as_int(logic [CB-1:0] v);
        longint r;
        r = $signed(v);
        return r;
    endfunction

    // Exact row of the sloped line at column x, truncated toward zero. SystemVerilog
    // integer division already truncates toward zero, so only the sign of dx is folded
    // into the numerator. A line whose registers now give dx of zero sits on start_y.
    function automatic longint exact_row(longint x);
        longint sx, sy, dx, dy, num;
        sx = as_int(cfg_sx);
        sy = as_int(cfg_sy);
        dx = as_int(cfg_ex) - sx;
        dy = as_int(cfg_ey) - sy;
        if (dx == 0) return sy;
        num = sy * dx + dy * (x - sx);
        if (dx < 0) begin
            dx  = -dx;
            num = -num;
        end
        return num / dx;
    endfunction

    // Moves the sloped walk onto column col_x: the target row is taken from the line, and a
    // jump of more than one row from fill_row starts a gap fill. The distance is measured
    // before the row wraps to the coordinate width, as the block does.
    function automatic void load_column();
        longint y, d;
        y        = exact_row(as_int(col_x));
        d        = y - as_int(fill_row);
        row_y    = y[CB-1:0];
        filling  = (d > 1) || (d < -1);
    endfunction

    // Advances the walk by one step beat and returns the output beat it must produce.
    function automatic t_pixel_beat next_pixel(logic restart);
        t_pixel_beat pb;
        longint      sx, ex, xfin, p, y, nx;
        logic        fin;
        pb = '0;
        sx = as_int(cfg_sx);
        ex = as_int(cfg_ex);
        if (restart) begin
            filling  = 1'b0;
            finished = 1'b0;
            if (sx == ex) begin
                kind_q = K_VERT;
                col_x  = cfg_sx;
                row_y  = cfg_sy;
                n_vert++;
            end else if (cfg_sy == cfg_ey) begin
                kind_q = K_HORZ;
                col_x  = cfg_sx;
                row_y  = cfg_sy;
                n_horz++;
            end else begin
                // A sloped walk always starts at the smaller x, so no gap at its first column.
                kind_q   = K_SLOPED;
                col_x    = (sx < ex) ? cfg_sx : cfg_ex;
                y        = exact_row(as_int(col_x));
                fill_row = y[CB-1:0];
                load_column();
                n_sloped++;
            end
        end
        if (finished) return pb;

        if (kind_q == K_SLOPED) begin
            xfin = (sx > ex) ? sx : ex;
            if (filling) begin
                // Rows between the previous column's row and the new one, at the new column.
                p  = as_int(fill_row);
                y  = as_int(row_y);
                pb = '{px: col_x, py: fill_row, valid: 1'b1, last: 1'b0};
                p  = p + ((p < y) ? 1 : -1);
                fill_row = p[CB-1:0];
                if (p == y) filling = 1'b0;
                n_gap_rows++;
            end else begin
                fin = (as_int(col_x) >= xfin);
                pb  = '{px: col_x, py: row_y, valid: 1'b1, last: fin};
                if (fin) begin
                    finished = 1'b1;
                end else begin
                    fill_row = row_y;
                    nx       = as_int(col_x) + 1;
                    col_x    = nx[CB-1:0];
                    load_column();
                end
            end
        end else if (kind_q == K_HORZ) begin
            // The end column itself is never emitted.
            if (as_int(col_x) == ex) begin
                finished = 1'b1;
                return pb;
            end
            nx    = as_int(col_x) + ((as_int(col_x) < ex) ? 1 : -1);
            pb    = '{px: col_x, py: row_y, valid: 1'b1, last: (nx == ex)};
            col_x = nx[CB-1:0];
            if (nx == ex) finished = 1'b1;
        end else begin
            // Vertical walk, the end row left out; coincident endpoints give nothing at all.
            y = as_int(cfg_ey);
            if (as_int(row_y) == y) begin
                finished = 1'b1;
                return pb;
            end
            nx    = as_int(row_y) + ((as_int(row_y) < y) ? 1 : -1);
            pb    = '{px: col_x, py: row_y, valid: 1'b1, last: (nx == y)};
            row_y = nx[CB-1:0];
            if (nx == y) finished = 1'b1;
        end
        return pb;
    endfunction

    // ------------------------------------------------------------------------------------
    // Step driver: takes beats from step_queue, predicts each one as it is accepted.
    // ------------------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_pixels.push_back(next_pixel(s_axis_tdata[0]));
                n_steps_sent++;
            end
            // A new beat may only be placed once the current one is gone.
            if (!s_axis_tvalid || s_axis_tready) begin
                if (step_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= step_queue.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Pixel monitor: compares every accepted output beat with the oldest expectation.
    // ------------------------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_pixel_beat got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{px: m_axis_tdata[CB-1:0], py: m_axis_tdata[2*CB-1:CB],
                        valid: m_axis_tuser[0], last: m_axis_tlast};
                n_beats_checked++;
                if (expected_pixels.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("[%0t] output beat with nothing expected: %s",
                                 $realtime,
                                 $sformatf("x=%0d y=%0d v=%b l=%b", $signed(got.px),
                                           $signed(got.py), got.valid, got.last));
                end else begin
                    want = expected_pixels.pop_front();
                    if (want.valid) n_pixels++;
                    if (want.last)  n_line_ends++;
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("[%0t] pixel mismatch: expected %s, got %s", $realtime,
                                     $sformatf("x=%0d y=%0d v=%b l=%b", $signed(want.px),
                                               $signed(want.py), want.valid, want.last),
                                     $sformatf("x=%0d y=%0d v=%b l=%b", $signed(got.px),
                                               $signed(got.py), got.valid, got.last));
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d step beats queued, %0d pixels outstanding",
                     n_cycles, step_queue.size(), expected_pixels.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------------------

    function automatic int pick(int lo, int hi);
        int r;
        r = $urandom_range(hi - lo);
        return lo + r;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    function automatic int near(int c, int w);
        return clamp_coord(c + pick(-w, w));
    endfunction

    function automatic int extreme_coord();
        case (pick(0, 3))
            0:       return -2048;
            1:       return 2047;
            2:       return -2047;
            default: return 2046;
        endcase
    endfunction

    function automatic int abs_int(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void queue_step(logic restart);
        step_queue.push_back({{(IN_TDATA_W-1){1'b0}}, restart});
        n_queued++;
    endfunction

    // A restart beat followed by n advancing beats.
    function automatic void queue_walk(int n);
        queue_step(1'b1);
        repeat (n) queue_step(1'b0);
    endfunction

    // One register write; the shadow copy changes at the accepting edge, when no step is
    // in flight, so the predictor never sees a half-updated line.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CB-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_START_X: cfg_sx = val;
            REG_START_Y: cfg_sy = val;
            REG_END_X:   cfg_ex = val;
            default:     cfg_ey = val;
        endcase
        n_reg_writes++;
    endtask

    task automatic set_line(input int sx, input int sy, input int ex, input int ey);
        write_reg(REG_START_X, sx[CB-1:0]);
        write_reg(REG_START_Y, sy[CB-1:0]);
        write_reg(REG_END_X, ex[CB-1:0]);
        write_reg(REG_END_Y, ey[CB-1:0]);
    endtask

    // Waits until every queued beat is accepted and every pixel is back, then a short pause.
    task automatic drain();
        do @(posedge i_clk);
        while (step_queue.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------------------

    initial begin
        int sx, sy, ex, ey, cx, cy, w, n, shape, mode;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Straight after reset there is no walk, so the beat is empty.
        queue_step(1'b0);
        drain();

        // Vertical line: rows 5, 6, 7, the end row left out, then one empty beat.
        set_line(3, 5, 3, 8);
        queue_walk(3);
        drain();

        // Coincident endpoints: nothing to emit, even on the restart beat.
        set_line(0, 0, 0, 0);
        queue_walk(0);
        drain();

        // Horizontal line at the coordinate extremes, walking toward smaller x.
        set_line(2047, -2048, 2044, -2048);
        queue_walk(3);
        drain();

        // Steep line given right to left: starts at the smaller x, then fills the rows
        // between row 5 and row 0 at the second column.
        set_line(1, 0, 0, 5);
        queue_walk(6);
        drain();

        // Registers rewritten in the middle of a sloped walk so that dx becomes zero: the
        // walk keeps its kind and runs on along start_y toward the new end column.
        set_line(0, 0, 3, 1);
        queue_walk(0);
        drain();
        write_reg(REG_START_X, 12'sd5);
        write_reg(REG_END_X, 12'sd5);
        repeat (3) queue_step(1'b0);
        drain();

        // Random part: one line setting per phase, most phases a clean walk of the whole
        // line (or a prefix of a long one), some continuing the old walk under changed
        // registers, and some with restart scattered at random.
        while (n_queued < TARGET_STEPS) begin
            idle_pct = (n_queued >= 700 && n_queued < 1000) ? 0 : 35;

            shape = pick(0, 9);
            cx = pick(-2048, 2047);
            cy = pick(-2048, 2047);
            w  = pick(1, 10);
            sx = near(cx, w);
            sy = near(cy, w);
            ex = near(cx, w);
            ey = near(cy, w);
            case (shape)
                0: ex = sx;
                1: ey = sy;
                2: begin
                    ex = sx;
                    ey = sy;
                end
                3: begin
                    // Steep, so columns jump by several rows.
                    ex = near(sx, 2);
                    ey = near(sy, 30);
                end
                4: begin
                    sx = pick(-2048, 2047);
                    sy = pick(-2048, 2047);
                    ex = pick(-2048, 2047);
                    ey = pick(-2048, 2047);
                end
                5: begin
                    sx = extreme_coord();
                    sy = extreme_coord();
                    ex = extreme_coord();
                    ey = extreme_coord();
                end
                default: ;
            endcase

            if ($urandom_range(99) < 15) begin
                // Only one register changes.
                case (pick(0, 3))
                    0:       write_reg(REG_START_X, sx[CB-1:0]);
                    1:       write_reg(REG_START_Y, sy[CB-1:0]);
                    2:       write_reg(REG_END_X, ex[CB-1:0]);
                    default: write_reg(REG_END_Y, ey[CB-1:0]);
                endcase
            end else begin
                set_line(sx, sy, ex, ey);
            end

            // Enough beats for the whole line plus a few empty ones, capped for long lines.
            n = abs_int(ex - sx) + abs_int(ey - sy) + 1;
            if (n > 40) n = 40;
            n = n + pick(0, 2);

            mode = pick(0, 99);
            if (mode < 75) begin
                queue_walk(n);
            end else if (mode < 87) begin
                repeat (n) queue_step(1'b0);
            end else begin
                repeat (n) queue_step($urandom_range(3) == 0);
            end
            drain();
        end

        // Any stray output beat in this window is flagged by the monitor.
        repeat (50) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            n_errors += expected_pixels.size();
            $display("%0d expected pixels never arrived", expected_pixels.size());
        end

        $display("Drove %0d step beats and %0d register writes; checked %0d output beats,",
                 n_steps_sent, n_reg_writes, n_beats_checked);
        $display("%0d of them pixels and %0d line ends. Walks restarted: %0d vertical, %s",
                 n_pixels, n_line_ends, n_vert,
                 $sformatf("%0d horizontal, %0d sloped, with %0d gap-fill rows.",
                           n_horz, n_sloped, n_gap_rows));
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
